FILE: design/pdht_pkg.sv
// ----------------------------------------------------------------------------
// Polled device health table package
// Shared types, opcodes, status codes and register indexes.
// ----------------------------------------------------------------------------
package pdht_pkg;

   // Request opcodes. Codes 6 and 7 behave as a query.
   localparam logic [2:0] OP_SET_ONLINE   = 3'd0;
   localparam logic [2:0] OP_POLL_REPLY   = 3'd1;
   localparam logic [2:0] OP_POLL_FAIL    = 3'd2;
   localparam logic [2:0] OP_CONTROL_DONE = 3'd3;
   localparam logic [2:0] OP_NEXT_POLL    = 3'd4;
   localparam logic [2:0] OP_QUERY        = 3'd5;

   // Response status codes.
   localparam logic [1:0] ST_CHANGED   = 2'd0;
   localparam logic [1:0] ST_BAD_ADDR  = 2'd1;
   localparam logic [1:0] ST_NO_CHANGE = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISC_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOV_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FAN_CODE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAULT_LEVEL     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVALID_FAN     = 3'd4;

   // Saturation limit of the miss and recovery counters, and the fan code
   // held by an entry that was never written since reset.
   localparam logic [7:0] SAT_LIMIT       = 8'hFF;
   localparam logic [7:0] RESET_FAN_CODE  = 8'hFF;

   typedef struct packed {
      logic       cfg;
      logic       valid;
      logic       disc;
      logic [7:0] miss;
      logic [7:0] recov;
      logic [7:0] fan_one;
      logic [7:0] fan_two;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{
      cfg: 1'b0, valid: 1'b0, disc: 1'b0, miss: 8'd0, recov: 8'd0,
      fan_one: RESET_FAN_CODE, fan_two: RESET_FAN_CODE
   };

   typedef struct packed {
      logic [7:0] disconnect_threshold;
      logic [7:0] recovery_threshold;
      logic [7:0] max_fan_code;
      logic [7:0] fault_code_level;
      logic [7:0] invalid_fan_code;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  slave_address;
      logic        online_flag;
      logic [15:0] fan_one_word;
      logic [15:0] fan_two_word;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  picked_address;
      logic        is_configured;
      logic        is_active;
      logic        is_disconnected;
      logic [7:0]  fan_one_state;
      logic [7:0]  fan_two_state;
      logic [31:0] revision;
      logic [7:0]  online_count;
      logic [7:0]  active_count;
      logic [7:0]  fault_count;
   } rsp_type;

   // Outcome of applying one request to one entry.
   typedef struct packed {
      entry_type  entry;
      logic       bump;
      logic [1:0] status;
   } upd_type;

endpackage

FILE: design/pdht_slot_mem.sv
// ----------------------------------------------------------------------------
// Polled device health table entry memory
// One-write, one-read synchronous memory with per-entry written bits.
// ----------------------------------------------------------------------------
module pdht_slot_mem import pdht_pkg::*; #(
   parameter int unsigned TABLE_SLAVES = 32,
   localparam int unsigned IDX_W = (TABLE_SLAVES > 1) ? $clog2(TABLE_SLAVES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_entry,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  entry_type        wr_entry
);

   entry_type              slots_ff [TABLE_SLAVES];
   logic [TABLE_SLAVES-1:0] filled_ff;
   entry_type              rd_data_ff;
   logic                   rd_filled_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_idx] <= wr_entry;
      end
   end

   // An entry not written since reset reads as the reset entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (wr_en) begin
         filled_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff   <= slots_ff[rd_idx];
         rd_filled_ff <= filled_ff[rd_idx];
      end
   end

   assign rd_entry = rd_filled_ff ? rd_data_ff : RESET_ENTRY;

endmodule

FILE: design/pdht_entry_update.sv
// ----------------------------------------------------------------------------
// Polled device health table entry update
// Applies one request to one entry: online changes, poll replies, misses.
// ----------------------------------------------------------------------------
module pdht_entry_update import pdht_pkg::*; (
   input  entry_type entry_in,
   input  req_type   req,
   input  cfg_type   cfg,
   output upd_type   upd
);

   entry_type  e;
   logic       bump;
   logic [1:0] status;
   logic [7:0] miss_inc;
   logic [7:0] recov_inc;
   logic       fan_bad;
   logic       is_fail;
   logic       changed;

   assign miss_inc  = (entry_in.miss < SAT_LIMIT) ? entry_in.miss + 8'd1 : entry_in.miss;
   assign recov_inc = (entry_in.recov < SAT_LIMIT) ? entry_in.recov + 8'd1 : entry_in.recov;
   assign fan_bad   = (req.fan_one_word > {8'd0, cfg.max_fan_code})
                   || (req.fan_two_word > {8'd0, cfg.max_fan_code});

   always_comb begin
      e       = entry_in;
      bump    = 1'b0;
      status  = ST_NO_CHANGE;
      is_fail = 1'b0;
      changed = 1'b0;
      case (req.opcode)
         OP_SET_ONLINE: begin
            if (entry_in.cfg != req.online_flag) begin
               e.cfg     = req.online_flag;
               e.valid   = 1'b0;
               e.disc    = 1'b0;
               e.miss    = 8'd0;
               e.recov   = 8'd0;
               e.fan_one = cfg.invalid_fan_code;
               e.fan_two = cfg.invalid_fan_code;
               bump      = 1'b1;
               status    = ST_CHANGED;
            end
         end
         OP_POLL_REPLY, OP_POLL_FAIL: begin
            is_fail = (req.opcode == OP_POLL_FAIL) || fan_bad;
            if (entry_in.cfg && is_fail) begin
               e.recov = 8'd0;
               e.miss  = miss_inc;
               if ((miss_inc >= cfg.disconnect_threshold) && !entry_in.disc) begin
                  e.disc = 1'b1;
                  bump   = 1'b1;
                  status = ST_CHANGED;
               end
            end else if (entry_in.cfg) begin
               changed = (entry_in.fan_one != req.fan_one_word[7:0])
                      || (entry_in.fan_two != req.fan_two_word[7:0])
                      || !entry_in.valid;
               e.fan_one = req.fan_one_word[7:0];
               e.fan_two = req.fan_two_word[7:0];
               e.valid   = 1'b1;
               e.miss    = 8'd0;
               e.recov   = 8'd0;
               if (entry_in.disc) begin
                  e.recov = recov_inc;
                  if (recov_inc >= cfg.recovery_threshold) begin
                     e.disc  = 1'b0;
                     e.recov = 8'd0;
                     changed = 1'b1;
                  end
               end
               bump   = changed;
               status = changed ? ST_CHANGED : ST_NO_CHANGE;
            end
         end
         OP_CONTROL_DONE: begin
            status = ST_CHANGED;
         end
         default: begin
            status = ST_NO_CHANGE;
         end
      endcase
   end

   assign upd.entry  = e;
   assign upd.bump   = bump;
   assign upd.status = status;

endmodule

FILE: design/polled_device_health_table_top.sv
// ----------------------------------------------------------------------------
// Polled device health table
// Health table of polled bus slaves with a round-robin poll pointer.
// ----------------------------------------------------------------------------
// Usage: a request on req_* (valid/stall) carries one command for slave
// addresses 1 to TABLE_SLAVES. Every request yields exactly one response on
// rsp_* (valid/stall) with the addressed or picked entry, the revision count
// and the online, active and fault totals. Thresholds and fan code limits are
// written through csr_* while the block is idle; csr_ready is always high.
// Sequence: a request for a table entry goes through a read, a write-back,
// the count pass and the tail and finish steps that drain it before the
// response is presented. Next-poll and requests outside the table skip the
// read and write-back. The count pass, which reads every entry once through
// the single memory read port, is the longest part of this; it also finds
// the next configured slave for next-poll. One request is in flight at a
// time: the block takes no new request until the last one has left the
// finishing step for the output register.
// A finished response sits in the output register; the block takes the next
// request while that response waits. If the receiver stalls, the following
// response is held back and req_stall stays high until the register frees.
// Reset (synchronous, active high) marks every entry offline with invalid fan
// codes, sets the poll pointer to 1 and clears the revision.
// ----------------------------------------------------------------------------
module polled_device_health_table_top import pdht_pkg::*; #(
   parameter int unsigned TABLE_SLAVES = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   localparam int unsigned IDX_W = (TABLE_SLAVES > 1) ? $clog2(TABLE_SLAVES) : 1;
   localparam logic [7:0] LAST_ADDR = 8'(TABLE_SLAVES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLAVES - 1);

   // Sequencer: read the addressed entry, write it back modified, then sweep
   // every entry to rebuild the totals and find the next-poll candidate.
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_MODIFY = 6'b000100,
      S_SCAN   = 6'b001000,
      S_TAIL   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   cfg_type    cfg_ff, cfg_in;
   req_type    req_ff, req_in;
   logic       addr_ok_ff, addr_ok_in;
   logic [1:0] status_ff, status_in;
   entry_type  shown_ff, shown_in;
   logic [7:0] ptr_ff, ptr_in;
   logic [31:0] rev_ff, rev_in;

   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             scan_pipe_ff, scan_pipe_in;
   logic [IDX_W-1:0] scan_tag_ff, scan_tag_in;

   logic [7:0] on_cnt_ff, on_cnt_in;
   logic [7:0] act_cnt_ff, act_cnt_in;
   logic [7:0] flt_cnt_ff, flt_cnt_in;

   // Candidates for next-poll: the first configured slave at or above the
   // pointer, and the first configured slave overall for the wrap case.
   logic       ge_found_ff, ge_found_in;
   logic [7:0] ge_addr_ff, ge_addr_in;
   entry_type  ge_entry_ff, ge_entry_in;
   logic       any_found_ff, any_found_in;
   logic [7:0] any_addr_ff, any_addr_in;
   entry_type  any_entry_ff, any_entry_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic             req_take;
   logic             rsp_free;
   logic [7:0]       addr_m1;
   logic [IDX_W-1:0] entry_idx;
   logic             rd_en;
   logic [IDX_W-1:0] rd_idx;
   entry_type        rd_entry;
   logic             wr_en;
   upd_type          upd;
   logic [7:0]       scan_addr;
   logic             scan_active;
   logic             scan_fault;
   logic             pick_found;
   logic [7:0]       pick_addr;
   entry_type        pick_entry;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign addr_m1   = req_ff.slave_address - 8'd1;
   assign entry_idx = addr_m1[IDX_W-1:0];

   assign rd_en  = (state_ff == S_READ) || (state_ff == S_SCAN);
   assign rd_idx = (state_ff == S_SCAN) ? scan_idx_ff : entry_idx;
   assign wr_en  = (state_ff == S_MODIFY);

   pdht_slot_mem #(
      .TABLE_SLAVES (TABLE_SLAVES)
   ) u_slot_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_idx   (entry_idx),
      .wr_entry (upd.entry)
   );

   pdht_entry_update u_entry_update (
      .entry_in (rd_entry),
      .req      (req_ff),
      .cfg      (cfg_ff),
      .upd      (upd)
   );

   // Classification of the entry arriving from the sweep.
   assign scan_addr   = 8'(scan_tag_ff) + 8'd1;
   assign scan_active = rd_entry.cfg && rd_entry.valid && !rd_entry.disc;
   assign scan_fault  = rd_entry.cfg && (rd_entry.disc || (rd_entry.valid
                     && ((rd_entry.fan_one >= cfg_ff.fault_code_level)
                     || (rd_entry.fan_two >= cfg_ff.fault_code_level))));

   assign pick_found = ge_found_ff || any_found_ff;
   assign pick_addr  = ge_found_ff ? ge_addr_ff : any_addr_ff;
   assign pick_entry = ge_found_ff ? ge_entry_ff : any_entry_ff;

   always_comb begin
      state_in     = state_ff;
      cfg_in       = cfg_ff;
      req_in       = req_ff;
      addr_ok_in   = addr_ok_ff;
      status_in    = status_ff;
      shown_in     = shown_ff;
      ptr_in       = ptr_ff;
      rev_in       = rev_ff;
      scan_idx_in  = scan_idx_ff;
      scan_pipe_in = 1'b0;
      scan_tag_in  = scan_idx_ff;
      on_cnt_in    = on_cnt_ff;
      act_cnt_in   = act_cnt_ff;
      flt_cnt_in   = flt_cnt_ff;
      ge_found_in  = ge_found_ff;
      ge_addr_in   = ge_addr_ff;
      ge_entry_in  = ge_entry_ff;
      any_found_in = any_found_ff;
      any_addr_in  = any_addr_ff;
      any_entry_in = any_entry_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DISC_THRESHOLD:  cfg_in.disconnect_threshold = csr_wdata;
            CSR_RECOV_THRESHOLD: cfg_in.recovery_threshold   = csr_wdata;
            CSR_MAX_FAN_CODE:    cfg_in.max_fan_code         = csr_wdata;
            CSR_FAULT_LEVEL:     cfg_in.fault_code_level     = csr_wdata;
            CSR_INVALID_FAN:     cfg_in.invalid_fan_code     = csr_wdata;
            default: begin
            end
         endcase
      end

      // Accumulate the entry that the sweep read in the previous cycle.
      if (scan_pipe_ff) begin
         on_cnt_in  = on_cnt_ff + 8'(rd_entry.cfg);
         act_cnt_in = act_cnt_ff + 8'(scan_active);
         flt_cnt_in = flt_cnt_ff + 8'(scan_fault);
         if (rd_entry.cfg && !any_found_ff) begin
            any_found_in = 1'b1;
            any_addr_in  = scan_addr;
            any_entry_in = rd_entry;
         end
         if (rd_entry.cfg && !ge_found_ff && (scan_addr >= ptr_ff)) begin
            ge_found_in = 1'b1;
            ge_addr_in  = scan_addr;
            ge_entry_in = rd_entry;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               req_in       = req_payload;
               addr_ok_in   = (req_payload.slave_address != 8'd0)
                           && (req_payload.slave_address <= LAST_ADDR);
               status_in    = ST_BAD_ADDR;
               scan_idx_in  = '0;
               on_cnt_in    = 8'd0;
               act_cnt_in   = 8'd0;
               flt_cnt_in   = 8'd0;
               ge_found_in  = 1'b0;
               any_found_in = 1'b0;
               if ((req_payload.opcode != OP_NEXT_POLL) && addr_ok_in) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_READ: begin
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            shown_in  = upd.entry;
            status_in = upd.status;
            if (upd.bump) begin
               rev_in = rev_ff + 32'd1;
            end
            if (req_ff.opcode == OP_CONTROL_DONE) begin
               ptr_in = req_ff.slave_address;
            end
            state_in = S_SCAN;
         end
         S_SCAN: begin
            scan_pipe_in = 1'b1;
            scan_tag_in  = scan_idx_ff;
            scan_idx_in  = scan_idx_ff + IDX_W'(1);
            if (scan_idx_ff == LAST_IDX) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.revision        = rev_ff;
               rsp_in.online_count    = on_cnt_ff;
               rsp_in.active_count    = act_cnt_ff;
               rsp_in.fault_count     = flt_cnt_ff;
               rsp_in.picked_address  = 8'd0;
               rsp_in.status          = status_ff;
               rsp_in.is_configured   = 1'b0;
               rsp_in.is_active       = 1'b0;
               rsp_in.is_disconnected = 1'b0;
               rsp_in.fan_one_state   = cfg_ff.invalid_fan_code;
               rsp_in.fan_two_state   = cfg_ff.invalid_fan_code;
               if (req_ff.opcode == OP_NEXT_POLL) begin
                  rsp_in.status = pick_found ? ST_CHANGED : ST_NO_CHANGE;
                  if (pick_found) begin
                     rsp_in.picked_address  = pick_addr;
                     rsp_in.is_configured   = 1'b1;
                     rsp_in.is_active       = pick_entry.valid && !pick_entry.disc;
                     rsp_in.is_disconnected = pick_entry.disc;
                     rsp_in.fan_one_state   = pick_entry.fan_one;
                     rsp_in.fan_two_state   = pick_entry.fan_two;
                     ptr_in = (pick_addr == LAST_ADDR) ? 8'd1 : pick_addr + 8'd1;
                  end
               end else if (addr_ok_ff) begin
                  rsp_in.is_configured   = shown_ff.cfg;
                  rsp_in.is_active       = shown_ff.cfg && shown_ff.valid && !shown_ff.disc;
                  rsp_in.is_disconnected = shown_ff.cfg && shown_ff.disc;
                  rsp_in.fan_one_state   = shown_ff.fan_one;
                  rsp_in.fan_two_state   = shown_ff.fan_two;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                     <= S_IDLE;
         cfg_ff.disconnect_threshold  <= 8'd3;
         cfg_ff.recovery_threshold    <= 8'd2;
         cfg_ff.max_fan_code          <= 8'd3;
         cfg_ff.fault_code_level      <= 8'd2;
         cfg_ff.invalid_fan_code      <= 8'd255;
         ptr_ff                       <= 8'd1;
         rev_ff                       <= 32'd0;
         scan_pipe_ff                 <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         ptr_ff       <= ptr_in;
         rev_ff       <= rev_in;
         scan_pipe_ff <= scan_pipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      addr_ok_ff   <= addr_ok_in;
      status_ff    <= status_in;
      shown_ff     <= shown_in;
      scan_idx_ff  <= scan_idx_in;
      scan_tag_ff  <= scan_tag_in;
      on_cnt_ff    <= on_cnt_in;
      act_cnt_ff   <= act_cnt_in;
      flt_cnt_ff   <= flt_cnt_in;
      ge_found_ff  <= ge_found_in;
      ge_addr_ff   <= ge_addr_in;
      ge_entry_ff  <= ge_entry_in;
      any_found_ff <= any_found_in;
      any_addr_ff  <= any_addr_in;
      any_entry_ff <= any_entry_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A new response appears only out of the finishing step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside the finishing step");

   // The poll pointer always names a slave inside the table.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (ptr_ff != 8'd0) && (ptr_ff <= LAST_ADDR))
      else $error("poll pointer out of range");

   // Active and faulty slaves are always a subset of the configured ones.
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.active_count <= rsp_ff.online_count)
                     && (rsp_ff.fault_count <= rsp_ff.online_count)))
      else $error("totals inconsistent");

   // Write-back only targets a valid entry of the addressed request.
   a_write_addr: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (addr_ok_ff && (req_ff.opcode != OP_NEXT_POLL)
              && ($past(state_ff) == S_READ)))
      else $error("entry write without a matching read");

endmodule

FILE: bench/health_table_checker.sv
// ----------------------------------------------------------------------------
// Health table response checker
// Watches the request, response and register channels of the polled device
// health table. It keeps its own copy of the table and settings, works out
// the response of every accepted request, and compares each response field by
// field with the oldest one waiting.
// ----------------------------------------------------------------------------
module health_table_checker import pdht_pkg::*; #(
   parameter int unsigned TABLE_SLAVES = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output int unsigned            failures,
   output int unsigned            backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   entry_type   slaves [TABLE_SLAVES];
   cfg_type     settings;
   logic [7:0]  poll_pointer;
   logic [31:0] revision;
   rsp_type     pending_responses [$];
   rsp_type     oldest;
   int unsigned mismatch_total = 0;
   int unsigned waiting = 0;

   assign failures = mismatch_total;
   assign backlog  = waiting;

   function automatic logic addr_in_table(input logic [7:0] a);
      return (a >= 8'd1) && (a <= TABLE_SLAVES);
   endfunction

   function automatic logic is_active(input entry_type e);
      return e.cfg && e.valid && !e.disc;
   endfunction

   function automatic logic is_fault(input entry_type e);
      if (!e.cfg) return 1'b0;
      if (e.disc) return 1'b1;
      return e.valid && (e.fan_one >= settings.fault_code_level ||
                         e.fan_two >= settings.fault_code_level);
   endfunction

   function automatic void clear_entry(input int idx);
      slaves[idx].valid   = 1'b0;
      slaves[idx].disc    = 1'b0;
      slaves[idx].miss    = 8'd0;
      slaves[idx].recov   = 8'd0;
      slaves[idx].fan_one = settings.invalid_fan_code;
      slaves[idx].fan_two = settings.invalid_fan_code;
   endfunction

   // A missed poll. Returns 1 when it makes a visible change.
   function automatic logic record_miss(input int idx);
      slaves[idx].recov = 8'd0;
      if (slaves[idx].miss < SAT_LIMIT) slaves[idx].miss = slaves[idx].miss + 8'd1;
      if (slaves[idx].miss >= settings.disconnect_threshold && !slaves[idx].disc) begin
         slaves[idx].disc = 1'b1;
         revision = revision + 32'd1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // A good poll with in-range fan codes.
   function automatic logic record_reply(input int idx, input logic [7:0] f1,
                                         input logic [7:0] f2);
      logic moved;
      moved = (slaves[idx].fan_one != f1) || (slaves[idx].fan_two != f2) ||
              !slaves[idx].valid;
      slaves[idx].fan_one = f1;
      slaves[idx].fan_two = f2;
      slaves[idx].valid   = 1'b1;
      slaves[idx].miss    = 8'd0;
      if (slaves[idx].disc) begin
         if (slaves[idx].recov < SAT_LIMIT) slaves[idx].recov = slaves[idx].recov + 8'd1;
         if (slaves[idx].recov >= settings.recovery_threshold) begin
            slaves[idx].disc  = 1'b0;
            slaves[idx].recov = 8'd0;
            moved = 1'b1;
         end
      end else begin
         slaves[idx].recov = 8'd0;
      end
      if (moved) revision = revision + 32'd1;
      return moved;
   endfunction

   // Applies one request to the table copy and returns its response.
   function automatic rsp_type apply_command(input req_type r);
      rsp_type     res;
      logic [7:0]  slot;
      logic [7:0]  shown;
      int          n;
      int          idx;
      int unsigned online;
      int unsigned active;
      int unsigned faulty;
      res = '0;
      res.status = ST_NO_CHANGE;
      shown = 8'd0;
      if (r.opcode == OP_NEXT_POLL) begin
         for (n = 0; n < TABLE_SLAVES && res.picked_address == 8'd0; n++) begin
            slot = addr_in_table(poll_pointer) ? poll_pointer : 8'd1;
            poll_pointer = (slot >= TABLE_SLAVES) ? 8'd1 : slot + 8'd1;
            if (slaves[slot - 1].cfg) res.picked_address = slot;
         end
         res.status = (res.picked_address != 8'd0) ? ST_CHANGED : ST_NO_CHANGE;
         shown = res.picked_address;
      end else if (!addr_in_table(r.slave_address)) begin
         res.status = ST_BAD_ADDR;
      end else begin
         shown = r.slave_address;
         idx = r.slave_address - 1;
         case (r.opcode)
            OP_SET_ONLINE: begin
               if (slaves[idx].cfg != r.online_flag) begin
                  slaves[idx].cfg = r.online_flag;
                  clear_entry(idx);
                  revision = revision + 32'd1;
                  res.status = ST_CHANGED;
               end
            end
            OP_POLL_REPLY: begin
               if (slaves[idx].cfg) begin
                  if (r.fan_one_word > settings.max_fan_code ||
                      r.fan_two_word > settings.max_fan_code) begin
                     res.status = record_miss(idx) ? ST_CHANGED : ST_NO_CHANGE;
                  end else begin
                     res.status = record_reply(idx, r.fan_one_word[7:0],
                                               r.fan_two_word[7:0])
                                  ? ST_CHANGED : ST_NO_CHANGE;
                  end
               end
            end
            OP_POLL_FAIL: begin
               if (slaves[idx].cfg) res.status = record_miss(idx) ? ST_CHANGED : ST_NO_CHANGE;
            end
            OP_CONTROL_DONE: begin
               poll_pointer = r.slave_address;
               res.status = ST_CHANGED;
            end
            default: ;
         endcase
      end

      online = 0;
      active = 0;
      faulty = 0;
      for (n = 0; n < TABLE_SLAVES; n++) begin
         if (slaves[n].cfg) online++;
         if (is_active(slaves[n])) active++;
         if (is_fault(slaves[n])) faulty++;
      end
      res.online_count = online[7:0];
      res.active_count = active[7:0];
      res.fault_count  = faulty[7:0];
      res.revision     = revision;

      if (addr_in_table(shown)) begin
         res.is_configured   = slaves[shown - 1].cfg;
         res.is_active       = is_active(slaves[shown - 1]);
         res.is_disconnected = slaves[shown - 1].cfg && slaves[shown - 1].disc;
         res.fan_one_state   = slaves[shown - 1].fan_one;
         res.fan_two_state   = slaves[shown - 1].fan_two;
      end else begin
         res.fan_one_state = settings.invalid_fan_code;
         res.fan_two_state = settings.invalid_fan_code;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings.disconnect_threshold = 8'd3;
         settings.recovery_threshold   = 8'd2;
         settings.max_fan_code         = 8'd3;
         settings.fault_code_level     = 8'd2;
         settings.invalid_fan_code     = 8'd255;
         for (int i = 0; i < TABLE_SLAVES; i++) begin
            slaves[i].cfg = 1'b0;
            clear_entry(i);
         end
         poll_pointer = 8'd1;
         revision = 32'd0;
         pending_responses.delete();
         waiting = 0;
      end else begin
         // Responses are handled first so that a request taken in the same
         // cycle can never be matched against them.
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_total++;
            end else begin
               oldest = pending_responses.pop_front();
               waiting--;
               check_field("status", oldest.status, rsp_payload.status);
               check_field("picked_address", oldest.picked_address,
                           rsp_payload.picked_address);
               check_field("is_configured", oldest.is_configured, rsp_payload.is_configured);
               check_field("is_active", oldest.is_active, rsp_payload.is_active);
               check_field("is_disconnected", oldest.is_disconnected,
                           rsp_payload.is_disconnected);
               check_field("fan_one_state", oldest.fan_one_state, rsp_payload.fan_one_state);
               check_field("fan_two_state", oldest.fan_two_state, rsp_payload.fan_two_state);
               check_field("revision", oldest.revision, rsp_payload.revision);
               check_field("online_count", oldest.online_count, rsp_payload.online_count);
               check_field("active_count", oldest.active_count, rsp_payload.active_count);
               check_field("fault_count", oldest.fault_count, rsp_payload.fault_count);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DISC_THRESHOLD:  settings.disconnect_threshold = csr_wdata;
               CSR_RECOV_THRESHOLD: settings.recovery_threshold   = csr_wdata;
               CSR_MAX_FAN_CODE:    settings.max_fan_code         = csr_wdata;
               CSR_FAULT_LEVEL:     settings.fault_code_level     = csr_wdata;
               CSR_INVALID_FAN:     settings.invalid_fan_code     = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            pending_responses.push_back(apply_command(req_payload));
            waiting++;
         end
      end
   end

endmodule

FILE: bench/tb_polled_device_health_table_top.sv
// ----------------------------------------------------------------------------
// Polled device health table testbench
// Drives a short directed sequence and then several random phases, each under
// its own threshold and fan code settings, through the request channel. The
// checker beside the block predicts and compares every response; this module
// makes the stimulus, idles both channels at random and gives the verdict.
// ----------------------------------------------------------------------------
module tb_polled_device_health_table_top;
   import pdht_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_SLAVES = 32;

   // Opcodes 6 and 7 have no name in the package; they behave as a query.
   localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
   localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

   // Cycles without any handshake before the run is declared hung. The longest
   // legal quiet stretch is the long receiver hold-off plus one latency.
   localparam int unsigned STALL_LIMIT = 4000;

   // Length of the long receiver hold-off, and the response count spacing
   // between two such hold-offs.
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned HOLD_SPACING = 800;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_wdata = '0;

   int unsigned failures;
   int unsigned backlog;
   int unsigned quiet_cycles = 0;
   int unsigned responses_taken = 0;

   // While set, both sides stop idling so that requests run back to back.
   bit          burst_mode = 1'b0;

   // Largest accepted fan code under the current settings; it steers the
   // fan words so that most replies are in range.
   logic [7:0]  fan_ceiling = 8'd3;

   wire req_fire = req_valid && !req_stall;
   wire rsp_fire = rsp_valid && !rsp_stall;
   wire csr_fire = csr_valid && csr_ready;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   polled_device_health_table_top #(.TABLE_SLAVES(TABLE_SLAVES)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   health_table_checker #(.TABLE_SLAVES(TABLE_SLAVES)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .backlog     (backlog)
   );

   // The watchdog restarts its count on every handshake of any channel. If the
   // block stops moving for too long, the run ends as a failure.
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire || csr_fire) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_fire) responses_taken <= responses_taken + 1;
   end

   // Idle gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (burst_mode || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   // Now and then the run switches into a stretch where neither side idles.
   initial begin
      forever begin
         repeat ($urandom_range(300, 1500)) @(negedge clock);
         burst_mode = ($urandom_range(0, 3) == 0);
      end
   end

   // Receiver. It stalls the response channel for random stretches. Twice in
   // the run it holds off for a long time while the sender keeps offering
   // requests, so the block fills its output register and stalls its input.
   initial begin
      int unsigned gap;
      int unsigned open;
      int unsigned next_hold;
      next_hold = 100;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = idle_gap();
         if (responses_taken >= next_hold) begin
            next_hold = next_hold + HOLD_SPACING;
            gap = LONG_HOLD;
         end
         @(negedge clock);
         if (gap != 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         open = $urandom_range(1, 10);
         repeat (open - 1) @(negedge clock);
      end
   end

   // Offers one request after a random gap and returns at the rising edge at
   // which the block takes it. Valid stays high into the next request unless
   // a gap follows, so back-to-back requests need no extra low cycle.
   task automatic send_request(input req_type r);
      int unsigned gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Writes all five registers in a row. Only called while the block is idle.
   task automatic program_settings(input logic [7:0] disc_limit, input logic [7:0] recov_limit,
                                   input logic [7:0] fan_max, input logic [7:0] fault_level,
                                   input logic [7:0] invalid_code);
      write_register(CSR_DISC_THRESHOLD, disc_limit);
      write_register(CSR_RECOV_THRESHOLD, recov_limit);
      write_register(CSR_MAX_FAN_CODE, fan_max);
      write_register(CSR_FAULT_LEVEL, fault_level);
      write_register(CSR_INVALID_FAN, invalid_code);
      @(negedge clock);
      csr_valid = 1'b0;
      fan_ceiling = fan_max;
   endtask

   // Drops the request valid, waits until every predicted response has been
   // taken, and then lets the block finish any internal pass before the
   // registers are touched or the verdict is given.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (backlog != 0) @(negedge clock);
      repeat (TABLE_SLAVES + 8) @(negedge clock);
   endtask

   function automatic req_type make_request(input logic [2:0] op, input logic [7:0] addr,
                                            input logic flag, input logic [15:0] w1,
                                            input logic [15:0] w2);
      req_type r;
      r.opcode        = op;
      r.slave_address = addr;
      r.online_flag   = flag;
      r.fan_one_word  = w1;
      r.fan_two_word  = w2;
      return r;
   endfunction

   // Fan words mostly land in range, often in the low codes so that repeated
   // replies match; the rest sit on the limit, just past it, or anywhere.
   function automatic logic [15:0] random_fan_word();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 16'($urandom_range(0, (fan_ceiling < 8'd4) ? fan_ceiling : 4));
      if (roll < 70) return 16'($urandom_range(0, fan_ceiling));
      if (roll < 80) return {8'd0, fan_ceiling};
      if (roll < 88) return {8'd0, fan_ceiling} + 16'd1;
      return 16'($urandom_range(0, 65535));
   endfunction

   // Random request, weighted toward polls on a handful of low addresses so
   // that miss and recovery streaks actually build up.
   function automatic req_type random_request();
      req_type     r;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 12)      r.opcode = OP_SET_ONLINE;
      else if (roll < 47) r.opcode = OP_POLL_REPLY;
      else if (roll < 65) r.opcode = OP_POLL_FAIL;
      else if (roll < 70) r.opcode = OP_CONTROL_DONE;
      else if (roll < 85) r.opcode = OP_NEXT_POLL;
      else if (roll < 95) r.opcode = OP_QUERY;
      else                r.opcode = $urandom_range(0, 1) ? OP_SPARE_HIGH : OP_SPARE_LOW;
      roll = $urandom_range(0, 99);
      if (roll < 60)      r.slave_address = 8'($urandom_range(1, 8));
      else if (roll < 90) r.slave_address = 8'($urandom_range(1, TABLE_SLAVES));
      else if (roll < 95) r.slave_address = 8'd0;
      else                r.slave_address = 8'($urandom_range(TABLE_SLAVES + 1, 255));
      r.online_flag  = ($urandom_range(0, 9) < 7);
      r.fan_one_word = random_fan_word();
      r.fan_two_word = random_fan_word();
      return r;
   endfunction

   // Random phase. A poll is sometimes repeated on the same slave so that
   // disconnect and recovery thresholds are reached.
   task automatic run_random(input int unsigned count);
      int unsigned sent;
      int unsigned repeats;
      int unsigned k;
      req_type     r;
      sent = 0;
      while (sent < count) begin
         r = random_request();
         repeats = 1;
         if ((r.opcode == OP_POLL_REPLY || r.opcode == OP_POLL_FAIL) &&
             $urandom_range(0, 9) == 0) begin
            repeats = $urandom_range(2, 8);
         end
         for (k = 0; k < repeats; k++) begin
            send_request(r);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Reset values, written once so every register sees a write early.
      program_settings(8'd3, 8'd2, 8'd3, 8'd2, 8'd255);

      // Directed part under the reset settings. Addresses outside the table,
      // a pick with no slave configured, a set to the same state, a fan word
      // above the limit, a disconnect after three misses and a recovery after
      // two good polls, polls to an offline slave, a pointer move and a pick
      // that wraps past the end of the table, and the unused opcodes.
      send_request(make_request(OP_QUERY,        8'd0,   1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_QUERY,        8'd33,  1'b1, 16'h0000, 16'h0000));
      send_request(make_request(OP_POLL_REPLY,   8'd255, 1'b1, 16'hFFFF, 16'hFFFF));
      send_request(make_request(OP_NEXT_POLL,    8'd0,   1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_SET_ONLINE,   8'd1,   1'b1, 16'h0000, 16'h0000));
      send_request(make_request(OP_SET_ONLINE,   8'd1,   1'b1, 16'h0000, 16'h0000));
      send_request(make_request(OP_SET_ONLINE,   8'd32,  1'b1, 16'h0000, 16'h0000));
      send_request(make_request(OP_POLL_REPLY,   8'd1,   1'b0, 16'h0000, 16'h0001));
      send_request(make_request(OP_POLL_REPLY,   8'd1,   1'b0, 16'h0000, 16'h0001));
      send_request(make_request(OP_POLL_REPLY,   8'd1,   1'b0, 16'h8000, 16'h0003));
      send_request(make_request(OP_POLL_FAIL,    8'd1,   1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_POLL_FAIL,    8'd1,   1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_POLL_FAIL,    8'd1,   1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_POLL_REPLY,   8'd1,   1'b0, 16'h0002, 16'h0003));
      send_request(make_request(OP_POLL_REPLY,   8'd1,   1'b0, 16'h0002, 16'h0003));
      send_request(make_request(OP_POLL_REPLY,   8'd5,   1'b0, 16'h0001, 16'h0001));
      send_request(make_request(OP_POLL_FAIL,    8'd7,   1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_CONTROL_DONE, 8'd31,  1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_NEXT_POLL,    8'd0,   1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_NEXT_POLL,    8'd0,   1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_CONTROL_DONE, 8'd0,   1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_SPARE_LOW,    8'd1,   1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_SPARE_HIGH,   8'd32,  1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_SET_ONLINE,   8'd32,  1'b0, 16'h0000, 16'h0000));
      send_request(make_request(OP_SET_ONLINE,   8'd1,   1'b0, 16'hFFFF, 16'hFFFF));
      wait_idle();

      // Thresholds of one, widest fan range, every stored code a fault.
      program_settings(8'd1, 8'd1, 8'd254, 8'd0, 8'd0);
      run_random(275);
      wait_idle();

      // Highest thresholds, only fan code zero accepted, no fan faults.
      program_settings(8'd255, 8'd255, 8'd0, 8'd254, 8'd255);
      run_random(275);
      wait_idle();

      // Zero thresholds: the first miss disconnects, the first good poll
      // recovers.
      program_settings(8'd0, 8'd0, 8'd7, 8'd4, 8'hA5);
      run_random(275);
      wait_idle();

      program_settings(8'd2, 8'd3, 8'd15, 8'd8, 8'h5A);
      run_random(275);
      wait_idle();

      program_settings(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                       8'($urandom_range(1, 20)), 8'($urandom_range(0, 20)),
                       8'($urandom_range(0, 255)));
      run_random(275);
      wait_idle();

      if (failures == 0 && backlog == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/pdht_pkg.sv
design/pdht_slot_mem.sv
design/pdht_entry_update.sv
design/polled_device_health_table_top.sv
bench/health_table_checker.sv
bench/tb_polled_device_health_table_top.sv
